// ===== hdl/roi_pkg.sv =====
// Shared types and constants for the ray / oriented box slab test.
// No dependencies; used by ray_obb_slab_intersect.
`default_nettype none
package roi_pkg;
  localparam int COMPONENT_BITS_DEF = 21;
  localparam int FRACTION_BITS_DEF  = 10;
  localparam int THR_W              = 21;
  localparam int FAR_W              = 31;
  localparam int QUO_W              = 31;
  localparam int CFG_IDX_W          = 2;
  localparam int IN_W               = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT = 2'd1;

  localparam logic [THR_W-1:0] THR_RESET = 21'd1049;
  localparam logic [FAR_W-1:0] FAR_RESET = 31'd102400000;

  // per-axis flags that ride alongside the dividers
  typedef struct packed {
    logic par;     // slab treated as parallel
    logic pmiss;   // origin outside a parallel slab
    logic neg_lo;  // quotient sign, low corner
    logic neg_hi;  // quotient sign, high corner
    logic sat_lo;  // quotient magnitude out of range, low corner
    logic sat_hi;  // quotient magnitude out of range, high corner
  } roi_side_t;
endpackage
`default_nettype wire

// ===== hdl/roi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Uses no package; instantiated by ray_obb_slab_intersect.
`default_nettype none
module roi_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 44,
  parameter int QUO_W = 31
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);
  localparam int W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [NUM_W-1:0] rem_r  [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W];
  logic [NUM_W-1:0] rem_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_st
    localparam int B = QUO_W - 1 - s;
    logic [W-1:0] sh;
    logic [W-1:0] diff;
    logic         ge;

    if (s == 0) begin : g_first
      assign rem_in[s] = num;
      assign den_in[s] = den;
      assign quo_in[s] = '0;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign quo_in[s] = quo_r[s-1];
    end

    always_comb begin
      sh   = W'(den_in[s]) << B;
      ge   = W'(rem_in[s]) >= sh;
      diff = W'(rem_in[s]) - sh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[NUM_W-1:0] : rem_in[s];
        den_r[s] <= den_in[s];
        quo_r[s] <= quo_in[s] | (ge ? (QUO_W'(1) << B) : '0);
      end
    end
  end

  assign quo = quo_r[QUO_W-1];
endmodule
`default_nettype wire

// ===== hdl/ray_obb_slab_intersect.sv =====
// Top level of the ray / oriented box slab test pipeline.
// Depends on roi_pkg and roi_div.
`default_nettype none
// Tests one ray against one oriented box per item and returns a hit flag and
// the entry distance in Q.10. Unless held by out_stall, the pipeline takes one
// item every cycle and holds QUO_W + 5 items in flight, in these stages:
// unpack and origin delta, the eighteen dot-product multiplies, the
// dot sums and slab numerators, sign and range preparation, one cycle per
// quotient bit in six parallel dividers, and the final clip of the entry and
// exit distances. The dividers make up most of the stages. The whole pipe
// advances together and halts only while a finished item waits at the output
// under out_stall, so in_stall follows out_stall when the output is full.
// Quotients are clamped to the range -1 .. 2^31, which leaves every compare
// against the entry and exit bounds unchanged. Configuration writes are
// always taken (cfg_ready is tied high) and must land while the pipe is empty.
module ray_obb_slab_intersect #(
  parameter int COMPONENT_BITS = roi_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = roi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [roi_pkg::IN_W-1:0]      in_ray_origin,
  input  wire logic [roi_pkg::IN_W-1:0]      in_ray_direction,
  input  wire logic [roi_pkg::IN_W-1:0]      in_box_low_corner,
  input  wire logic [roi_pkg::IN_W-1:0]      in_box_high_corner,
  input  wire logic [roi_pkg::IN_W-1:0]      in_frame_axis_x,
  input  wire logic [roi_pkg::IN_W-1:0]      in_frame_axis_y,
  input  wire logic [roi_pkg::IN_W-1:0]      in_frame_axis_z,
  input  wire logic [roi_pkg::IN_W-1:0]      in_frame_position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [roi_pkg::FAR_W-1:0]          out_entry_distance,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [roi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [roi_pkg::FAR_W-1:0]     cfg_data
);
  localparam int C   = COMPONENT_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int QB  = roi_pkg::QUO_W;
  localparam int DW  = C + 1;            // origin delta
  localparam int PEW = 2 * C + 1;        // axis * delta product
  localparam int PFW = 2 * C;            // direction * axis product
  localparam int EW  = 2 * C + 3;        // e
  localparam int FW  = 2 * C + 2;        // f
  localparam int NW  = ((EW > C + F) ? EW : C + F) + 1;  // e + corner
  localparam int AW  = NW + F;           // |numerator| scaled by 2^F
  localparam int SW  = ((AW > FW + QB) ? AW : FW + QB) + 1;
  localparam int TW  = QB + 2;           // clamped distance, signed

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [roi_pkg::THR_W-1:0] thr_r;
  logic [roi_pkg::FAR_W-1:0] far_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= roi_pkg::THR_RESET;
      far_r <= roi_pkg::FAR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        roi_pkg::CFG_THRESHOLD: thr_r <= cfg_data[roi_pkg::THR_W-1:0];
        roi_pkg::CFG_FAR_LIMIT: far_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: hold everything while the output item is not taken
  // ---------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------------
  // Stage 1: unpack components, form position - origin
  // ---------------------------------------------------------------------
  logic               v1_r;
  logic signed [DW-1:0] dlt_r [3];
  logic signed [C-1:0]  dir_r [3];
  logic signed [C-1:0]  lo1_r [3];
  logic signed [C-1:0]  hi1_r [3];
  logic signed [C-1:0]  ax1_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dlt_r[k] <= DW'($signed(in_frame_position[k*C +: C]))
                  - DW'($signed(in_ray_origin[k*C +: C]));
        dir_r[k] <= $signed(in_ray_direction[k*C +: C]);
        lo1_r[k] <= $signed(in_box_low_corner[k*C +: C]);
        hi1_r[k] <= $signed(in_box_high_corner[k*C +: C]);
        ax1_r[0][k] <= $signed(in_frame_axis_x[k*C +: C]);
        ax1_r[1][k] <= $signed(in_frame_axis_y[k*C +: C]);
        ax1_r[2][k] <= $signed(in_frame_axis_z[k*C +: C]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the eighteen products of the two dot products per axis
  // ---------------------------------------------------------------------
  logic                  v2_r;
  logic signed [PEW-1:0] pe_r [3][3];
  logic signed [PFW-1:0] pf_r [3][3];
  logic signed [C-1:0]   lo2_r [3];
  logic signed [C-1:0]   hi2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          pe_r[a][k] <= PEW'(ax1_r[a][k]) * PEW'(dlt_r[k]);
          pf_r[a][k] <= PFW'(ax1_r[a][k]) * PFW'(dir_r[k]);
        end
      end
      lo2_r <= lo1_r;
      hi2_r <= hi1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: sum into e and f, add the scaled corners
  // ---------------------------------------------------------------------
  logic                 v3_r;
  logic signed [FW-1:0] f_r   [3];
  logic signed [NW-1:0] nlo_r [3];
  logic signed [NW-1:0] nhi_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        f_r[a]   <= FW'(pf_r[a][0]) + FW'(pf_r[a][1]) + FW'(pf_r[a][2]);
        nlo_r[a] <= NW'(EW'(pe_r[a][0]) + EW'(pe_r[a][1]) + EW'(pe_r[a][2]))
                  + (NW'(lo2_r[a]) <<< F);
        nhi_r[a] <= NW'(EW'(pe_r[a][0]) + EW'(pe_r[a][1]) + EW'(pe_r[a][2]))
                  + (NW'(hi2_r[a]) <<< F);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: magnitudes, signs, parallel test and quotient range check
  // ---------------------------------------------------------------------
  logic              v4_r;
  logic [AW-1:0]     nlo_mag_r [3];
  logic [AW-1:0]     nhi_mag_r [3];
  logic [FW-1:0]     fmag_r    [3];
  roi_pkg::roi_side_t side4_r  [3];

  logic [NW-1:0]     lo_abs [3];
  logic [NW-1:0]     hi_abs [3];
  logic [FW-1:0]     f_abs  [3];
  logic [AW-1:0]     lo_sc  [3];
  logic [AW-1:0]     hi_sc  [3];
  logic [SW-1:0]     lim    [3];
  roi_pkg::roi_side_t side4_nxt [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_abs[a] = nlo_r[a][NW-1] ? NW'(-nlo_r[a]) : NW'(nlo_r[a]);
      hi_abs[a] = nhi_r[a][NW-1] ? NW'(-nhi_r[a]) : NW'(nhi_r[a]);
      f_abs[a]  = f_r[a][FW-1]   ? FW'(-f_r[a])   : FW'(f_r[a]);
      lo_sc[a]  = AW'(lo_abs[a]) << F;
      hi_sc[a]  = AW'(hi_abs[a]) << F;
      lim[a]    = SW'(f_abs[a]) << QB;
      side4_nxt[a].par    = !(f_abs[a] > FW'(thr_r));
      side4_nxt[a].pmiss  = (!nlo_r[a][NW-1] && (nlo_r[a] != '0)) || nhi_r[a][NW-1];
      side4_nxt[a].neg_lo = nlo_r[a][NW-1] ^ f_r[a][FW-1];
      side4_nxt[a].neg_hi = nhi_r[a][NW-1] ^ f_r[a][FW-1];
      side4_nxt[a].sat_lo = SW'(lo_sc[a]) >= lim[a];
      side4_nxt[a].sat_hi = SW'(hi_sc[a]) >= lim[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlo_mag_r <= lo_sc;
      nhi_mag_r <= hi_sc;
      fmag_r    <= f_abs;
      side4_r   <= side4_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Dividers: six in parallel, QB stages each; flags follow in lockstep
  // ---------------------------------------------------------------------
  logic [QB-1:0] q_lo [3];
  logic [QB-1:0] q_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    roi_div #(.NUM_W(AW), .DEN_W(FW), .QUO_W(QB)) u_div_lo (
      .clk (clk),
      .en  (en),
      .num (nlo_mag_r[a]),
      .den (fmag_r[a]),
      .quo (q_lo[a])
    );
    roi_div #(.NUM_W(AW), .DEN_W(FW), .QUO_W(QB)) u_div_hi (
      .clk (clk),
      .en  (en),
      .num (nhi_mag_r[a]),
      .den (fmag_r[a]),
      .quo (q_hi[a])
    );
  end

  logic               vd_r    [QB];
  roi_pkg::roi_side_t sided_r [QB][3];

  always_ff @(posedge clk) begin
    if (en) begin
      sided_r[0] <= side4_r;
      for (int s = 1; s < QB; s++) begin
        sided_r[s] <= sided_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits of the whole pipe
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int s = 0; s < QB; s++) begin
        vd_r[s] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      vd_r[0] <= v4_r;
      for (int s = 1; s < QB; s++) begin
        vd_r[s] <= vd_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Final stage: clamp quotients, clip entry / exit, drive the output item
  // ---------------------------------------------------------------------
  logic signed [TW-1:0] t_lo [3];
  logic signed [TW-1:0] t_hi [3];
  logic signed [TW-1:0] t1, t2, tmin, tmax;
  logic                 miss;
  roi_pkg::roi_side_t   sf [3];
  logic                 hit_nxt;
  logic [roi_pkg::FAR_W-1:0] dist_nxt;

  always_comb begin
    tmin = '0;
    tmax = TW'(far_r);
    miss = 1'b0;
    t1   = '0;
    t2   = '0;
    for (int a = 0; a < 3; a++) begin
      sf[a] = sided_r[QB-1][a];
      if (sf[a].sat_lo) begin
        t_lo[a] = sf[a].neg_lo ? TW'(-1) : (TW'(1) <<< QB);
      end else begin
        t_lo[a] = (sf[a].neg_lo && (q_lo[a] != '0)) ? TW'(-1) : TW'(q_lo[a]);
      end
      if (sf[a].sat_hi) begin
        t_hi[a] = sf[a].neg_hi ? TW'(-1) : (TW'(1) <<< QB);
      end else begin
        t_hi[a] = (sf[a].neg_hi && (q_hi[a] != '0)) ? TW'(-1) : TW'(q_hi[a]);
      end
      if (sf[a].par) begin
        if (sf[a].pmiss) begin
          miss = 1'b1;
        end
      end else begin
        t1 = (t_lo[a] > t_hi[a]) ? t_hi[a] : t_lo[a];
        t2 = (t_lo[a] > t_hi[a]) ? t_lo[a] : t_hi[a];
        if (t2 < tmax) begin
          tmax = t2;
        end
        if (t1 > tmin) begin
          tmin = t1;
        end
        if (tmax < tmin) begin
          miss = 1'b1;
        end
      end
    end
    hit_nxt  = !miss;
    dist_nxt = miss ? '0 : tmin[roi_pkg::FAR_W-1:0];
  end

  logic                      hit_r;
  logic [roi_pkg::FAR_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_entry_distance = dist_r;
endmodule
`default_nettype wire
